### hw/rtl/morph_pkg.sv
// shared types, constants and helper functions for the 3x3 morphology filter
package morph_pkg;

   // geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // field and counter widths
   localparam int PIX_W  = 8;
   localparam int DIM_W  = 11;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int OUT_W  = 10;
   localparam int IDX_W  = 2;

   localparam logic [PIX_W-1:0] PIX_MAX  = PIX_W'(255);
   localparam logic [PIX_W-1:0] PIX_ZERO = '0;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] REG_FILTER_MODE  = 2'd2;

   // register reset values
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   // filter modes
   localparam logic MODE_EROSION  = 1'b0;
   localparam logic MODE_DILATION = 1'b1;

   // item kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [PIX_W-1:0] pixel_value;
   } req_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] result_value;
      logic [OUT_W-1:0] result_col;
      logic [OUT_W-1:0] result_row;
      logic             frame_last;
   } rsp_item_type;

   // one column of the window, rows r-2, r-1, r
   typedef logic [2:0][PIX_W-1:0] column_type;

   // minimum or maximum of two pixels
   function automatic logic [PIX_W-1:0] pick2(input logic mode,
                                              input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
      logic take_a;
      take_a = (mode == MODE_DILATION) ? (a > b) : (a < b);
      return take_a ? a : b;
   endfunction

   // minimum or maximum of three pixels
   function automatic logic [PIX_W-1:0] pick3(input logic mode,
                                              input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
      return pick2(mode, pick2(mode, a, b), c);
   endfunction

   // reduction of one window column
   function automatic logic [PIX_W-1:0] pick_col(input logic mode, input column_type col);
      return pick3(mode, col[0], col[1], col[2]);
   endfunction

endpackage

### hw/rtl/morph_if.sv
// valid/ready channel interfaces for pixel requests and filter responses
interface morph_req_if;
   logic                      valid;
   logic                      ready;
   morph_pkg::req_item_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface morph_rsp_if;
   logic                      valid;
   logic                      ready;
   morph_pkg::rsp_item_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/morphology_3x3_min_max.sv
// 3x3 grayscale erosion / dilation over a raster pixel stream
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    req_type, pixel_value
//   rsp_chan  out  valid/ready    result_value, result_col, result_row, frame_last
//   csr_*     in   write enable   csr_index, csr_write_data (no read-back)
//
// one pixel per clock is taken while the response queue has room; the pixel closing a
// row of W >= 2 after the first row makes two responses, so the next request waits while
// the queue drains. a request is registered in stage one, its responses in the queue.
// the line store is a single 1024 x 16 memory read at the request, written on retire.
// reset is synchronous and clears counters, pipeline, queue, window and registers;
// the line store is not cleared. a stalled response holds one item in the stage.
module morphology_3x3_min_max (
   input  logic                             clock,
   input  logic                             reset,
   morph_req_if.sink                        req_chan,
   morph_rsp_if.source                      rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [morph_pkg::IDX_W-1:0]      csr_index,
   input  logic [morph_pkg::DIM_W-1:0]      csr_write_data
);
   import morph_pkg::*;

   localparam int WORD_W = 2 * PIX_W;

   // configuration registers
   logic [DIM_W-1:0] image_width_ff;
   logic [DIM_W-1:0] image_height_ff;
   logic             filter_mode_ff;

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // line store: upper byte two rows back, lower byte one row back
   logic [WORD_W-1:0] line_mem [MAX_WIDTH];
   logic [WORD_W-1:0] line_rd_ff;

   // stage one
   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s1_end_col_ff;
   logic             s1_last_row_ff;
   logic             s1_fwd_ff;
   logic [WORD_W-1:0] s1_fwd_data_ff;

   // window columns c-1 and c-2
   column_type win1_ff, win2_ff;

   // response queue
   rsp_item_type q0_ff, q1_ff;
   logic [1:0]   cnt_ff;

   // effective geometry and position
   logic [DIM_W-1:0] w_eff, h_eff;
   logic [COL_W-1:0] col_eff;
   logic [ROW_W-1:0] row_eff;
   logic [DIM_W-1:0] col_next;
   logic             drain_row;
   logic [PIX_W-1:0] pix_eff;

   logic accept, pop, room, s1_adv, fwd_hit;

   logic [WORD_W-1:0] line_raw;
   column_type        cur_col, prev1_col, prev2_col;
   logic [PIX_W-1:0]  red_cur, red_p1, red_p2;
   rsp_item_type      res0, res1;
   logic              has0, has1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         filter_mode_ff  <= MODE_EROSION;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_write_data;
            REG_IMAGE_HEIGHT: image_height_ff <= csr_write_data;
            REG_FILTER_MODE:  filter_mode_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // clamped geometry
   always_comb begin
      if (image_width_ff == '0)                  w_eff = DIM_W'(1);
      else if (int'(image_width_ff) > MAX_WIDTH) w_eff = DIM_W'(MAX_WIDTH);
      else                                       w_eff = image_width_ff;
      if (image_height_ff == '0)                   h_eff = DIM_W'(1);
      else if (int'(image_height_ff) > MAX_HEIGHT) h_eff = DIM_W'(MAX_HEIGHT);
      else                                         h_eff = image_height_ff;
   end

   // handshake
   assign pop    = rsp_chan.valid && rsp_chan.ready;
   assign room   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);
   assign s1_adv = s1_valid_ff && room;
   assign req_chan.ready = !s1_valid_ff || room;
   assign accept = req_chan.valid && req_chan.ready;

   // position of the incoming transaction
   always_comb begin
      col_eff   = (DIM_W'(col_ff) >= w_eff) ? '0 : col_ff;
      row_eff   = (DIM_W'(row_ff) > h_eff) ? ROW_W'(h_eff) : row_ff;
      drain_row = DIM_W'(row_eff) >= h_eff;
      pix_eff   = (!drain_row && req_chan.payload.req_type == KIND_PIXEL) ?
                  req_chan.payload.pixel_value : PIX_ZERO;
      col_next  = DIM_W'(col_eff) + DIM_W'(1);
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         if (col_next >= w_eff) begin
            col_in = '0;
            row_in = (DIM_W'(row_eff) + DIM_W'(1) > h_eff) ? '0 : row_eff + ROW_W'(1);
         end else begin
            col_in = COL_W'(col_next);
            row_in = row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage one holds the item whose line store read is in flight
   assign fwd_hit = s1_adv && (s1_col_ff == col_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff      <= col_eff;
         s1_row_ff      <= row_eff;
         s1_pix_ff      <= pix_eff;
         s1_end_col_ff  <= DIM_W'(col_eff) == w_eff - DIM_W'(1);
         s1_last_row_ff <= DIM_W'(row_eff) == h_eff;
         s1_fwd_ff      <= fwd_hit;
         s1_fwd_data_ff <= {line_raw[PIX_W-1:0], s1_pix_ff};
      end
   end

   // line store: read at accept, write back when stage one retires
   always_ff @(posedge clock) begin
      if (accept) begin
         line_rd_ff <= line_mem[col_eff];
      end
      if (s1_adv) begin
         line_mem[s1_col_ff] <= {line_raw[PIX_W-1:0], s1_pix_ff};
      end
   end

   // neighbourhood assembly with out-of-image rows and columns masked to zero
   always_comb begin
      line_raw   = s1_fwd_ff ? s1_fwd_data_ff : line_rd_ff;
      cur_col[0] = (s1_row_ff >= ROW_W'(2)) ? line_raw[WORD_W-1:PIX_W] : PIX_ZERO;
      cur_col[1] = (s1_row_ff >= ROW_W'(1)) ? line_raw[PIX_W-1:0] : PIX_ZERO;
      cur_col[2] = s1_pix_ff;
      prev1_col  = (s1_col_ff == '0) ? '0 : win1_ff;
      prev2_col  = (s1_col_ff == '0) ? '0 : win2_ff;
      red_cur    = pick_col(filter_mode_ff, cur_col);
      red_p1     = pick_col(filter_mode_ff, prev1_col);
      red_p2     = pick_col(filter_mode_ff, prev2_col);
   end

   // the two possible responses of the retiring item
   always_comb begin
      has0 = (s1_row_ff != '0) && (s1_col_ff != '0);
      has1 = (s1_row_ff != '0) && s1_end_col_ff;

      res0.result_value = pick3(filter_mode_ff, red_p2, red_p1, red_cur);
      res0.result_col   = OUT_W'(s1_col_ff - COL_W'(1));
      res0.result_row   = OUT_W'(s1_row_ff - ROW_W'(1));
      // an interior column is never the last column
      res0.frame_last   = 1'b0;

      res1.result_value = pick3(filter_mode_ff, red_p1, red_cur, PIX_ZERO);
      res1.result_col   = OUT_W'(s1_col_ff);
      res1.result_row   = OUT_W'(s1_row_ff - ROW_W'(1));
      res1.frame_last   = s1_last_row_ff;
   end

   // window shift on retire
   always_ff @(posedge clock) begin
      if (reset) begin
         win1_ff <= '0;
         win2_ff <= '0;
      end else if (s1_adv) begin
         win1_ff <= cur_col;
         win2_ff <= prev1_col;
      end
   end

   // response queue, two entries
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (s1_adv) begin
         cnt_ff <= 2'(has0) + 2'(has1);
      end else if (pop) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         q0_ff <= has0 ? res0 : res1;
         q1_ff <= res1;
      end else if (pop) begin
         q0_ff <= q1_ff;
      end
   end

   assign rsp_chan.valid   = cnt_ff != 2'd0;
   assign rsp_chan.payload = q0_ff;

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("response queue count out of range");

   a_retire_room: assert property (@(posedge clock) disable iff (reset)
      s1_adv |-> (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)))
      else $error("stage one retired into a full response queue");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!s1_valid_ff || s1_adv))
      else $error("stage one overwritten before retiring");

   a_pair_cols: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> q1_ff.result_col == q0_ff.result_col + OUT_W'(1))
      else $error("row end response pair out of column order");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !s1_adv) |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("response queue lost a transaction");

endmodule
